### sv/ssb_pkg.sv
// Package: shared widths and the queued job type for the sprite blitter.
package ssb_pkg;

  // Input field widths
  localparam int EDGE_W   = 12;  // sprite_left, sprite_top
  localparam int PIXIDX_W = 5;   // pixel_row, pixel_col
  localparam int COLOR_W  = 16;

  // Output field widths
  localparam int ADDR_W = 19;

  // Configuration
  localparam int SCALE_W   = 4;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam logic [0:0] REG_SCALE_FACTOR = 1'b0;  // register index, from paddr[2]
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

  // Internal widths: block offsets run 0..7, coordinates reach 2047 + 31*8 + 7
  localparam int OFS_W   = 3;
  localparam int PROD_W  = PIXIDX_W + SCALE_W;
  localparam int COORD_W = 13;
  localparam int ADDR_FULL_W = 23;

  // Default parameter values
  localparam int SCREEN_W_DEF        = 640;
  localparam int SCREEN_H_DEF        = 480;
  localparam int MAX_SCALE_DEF       = 8;
  localparam int SPRITE_MAX_SIDE_DEF = 32;

  localparam int QUEUE_DEPTH = 2;

  // One pixel's block, as handed from the front end to the back end
  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic                      in_bounds;
    logic [SCALE_W-1:0]        scale;
    logic [COLOR_W-1:0]        color;
  } ssb_job_t;

endpackage

### sv/ssb_if.sv
// Interfaces: sprite pixel input channel and framebuffer write output channel.
interface ssb_pix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ssb_pkg::EDGE_W-1:0]    sprite_left;
  logic signed [ssb_pkg::EDGE_W-1:0]    sprite_top;
  logic [ssb_pkg::PIXIDX_W-1:0]         pixel_row;
  logic [ssb_pkg::PIXIDX_W-1:0]         pixel_col;
  logic [ssb_pkg::COLOR_W-1:0]          pixel_color;

  modport source(output valid, sprite_left, sprite_top, pixel_row, pixel_col, pixel_color,
                 input ready);
  modport sink(input valid, sprite_left, sprite_top, pixel_row, pixel_col, pixel_color,
               output ready);
endinterface

interface ssb_wr_if;
  logic                          valid;
  logic                          ready;
  logic [ssb_pkg::ADDR_W-1:0]    fb_address;
  logic [ssb_pkg::COLOR_W-1:0]   fb_color;
  logic                          write_enable;
  logic                          last_write;

  modport source(output valid, fb_address, fb_color, write_enable, last_write,
                 input ready);
  modport sink(input valid, fb_address, fb_color, write_enable, last_write,
               output ready);
endinterface

### sv/ssb_front.sv
// Front end: takes a sprite pixel beat and works out its block origin and scale.
module ssb_front #(
  parameter int MAX_SCALE       = ssb_pkg::MAX_SCALE_DEF,
  parameter int SPRITE_MAX_SIDE = ssb_pkg::SPRITE_MAX_SIDE_DEF
) (
  ssb_pix_if.sink                        pix,
  input  logic [ssb_pkg::SCALE_W-1:0]    scale_factor,
  input  logic                           q_ready,
  output logic                           q_push,
  output ssb_pkg::ssb_job_t              q_job
);

  localparam logic [ssb_pkg::SCALE_W-1:0]  MAX_S    = ssb_pkg::SCALE_W'(MAX_SCALE);
  localparam logic [ssb_pkg::PIXIDX_W:0]   SIDE_LIM = (ssb_pkg::PIXIDX_W + 1)'(SPRITE_MAX_SIDE);

  logic [ssb_pkg::SCALE_W-1:0] s_eff;
  logic [ssb_pkg::PROD_W-1:0]  col_ofs;
  logic [ssb_pkg::PROD_W-1:0]  row_ofs;

  // zero reads as one, anything above the maximum saturates
  always_comb begin
    if (scale_factor == '0) begin
      s_eff = ssb_pkg::SCALE_W'(1);
    end else if (scale_factor > MAX_S) begin
      s_eff = MAX_S;
    end else begin
      s_eff = scale_factor;
    end
  end

  assign col_ofs = ssb_pkg::PROD_W'(pix.pixel_col) * ssb_pkg::PROD_W'(s_eff);
  assign row_ofs = ssb_pkg::PROD_W'(pix.pixel_row) * ssb_pkg::PROD_W'(s_eff);

  always_comb begin
    q_job.x0 = ssb_pkg::COORD_W'(pix.sprite_left)
             + $signed({{(ssb_pkg::COORD_W - ssb_pkg::PROD_W){1'b0}}, col_ofs});
    q_job.y0 = ssb_pkg::COORD_W'(pix.sprite_top)
             + $signed({{(ssb_pkg::COORD_W - ssb_pkg::PROD_W){1'b0}}, row_ofs});
    q_job.in_bounds = ({1'b0, pix.pixel_row} < SIDE_LIM) && ({1'b0, pix.pixel_col} < SIDE_LIM);
    q_job.scale  = s_eff;
    q_job.color  = pix.pixel_color;
  end

  assign pix.ready = q_ready;
  assign q_push    = pix.valid && q_ready;

endmodule

### sv/ssb_queue.sv
// Job queue: short register FIFO between the front and back ends.
module ssb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssb_pkg::ssb_job_t push_job,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output ssb_pkg::ssb_job_t pop_job
);

  localparam int PTR_W = (ssb_pkg::QUEUE_DEPTH > 1) ? $clog2(ssb_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ssb_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ssb_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ssb_pkg::QUEUE_DEPTH - 1);

  ssb_pkg::ssb_job_t slots [ssb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/ssb_back.sv
// Back end: walks one block row by row, clips each point and registers the write beat.
module ssb_back #(
  parameter int SCREEN_W = ssb_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = ssb_pkg::SCREEN_H_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ssb_pkg::ssb_job_t q_job,
  output logic              q_pop,
  ssb_wr_if.source          wr
);

  localparam logic signed [ssb_pkg::COORD_W-1:0] W_LIM = ssb_pkg::COORD_W'(SCREEN_W);
  localparam logic signed [ssb_pkg::COORD_W-1:0] H_LIM = ssb_pkg::COORD_W'(SCREEN_H);
  localparam logic [ssb_pkg::ADDR_FULL_W-1:0]    W_MUL = ssb_pkg::ADDR_FULL_W'(SCREEN_W);
  localparam int  AREA      = SCREEN_W * SCREEN_H;
  localparam bit  AREA_FITS = (AREA <= (1 << ssb_pkg::ADDR_W));
  localparam logic [ssb_pkg::ADDR_W:0] AREA_LIM = (ssb_pkg::ADDR_W + 1)'(AREA);
  localparam int  PAD_W = ssb_pkg::COORD_W - ssb_pkg::OFS_W;

  ssb_pkg::ssb_job_t              cur;
  logic                           cur_valid;
  logic [ssb_pkg::OFS_W-1:0]      dx;
  logic [ssb_pkg::OFS_W-1:0]      dy;
  logic                           advance;
  logic                           step;
  logic                           last_x;
  logic                           last_y;
  logic signed [ssb_pkg::COORD_W-1:0] px;
  logic signed [ssb_pkg::COORD_W-1:0] py;
  logic                           on_screen;
  logic [ssb_pkg::ADDR_FULL_W-1:0] addr_full;

  assign advance = !wr.valid || wr.ready;
  assign step    = cur_valid && advance;
  assign last_x  = ({1'b0, dx} == cur.scale - ssb_pkg::SCALE_W'(1));
  assign last_y  = ({1'b0, dy} == cur.scale - ssb_pkg::SCALE_W'(1));
  assign q_pop   = q_valid && (!cur_valid || (step && last_x && last_y));

  assign px = cur.x0 + $signed({{PAD_W{1'b0}}, dx});
  assign py = cur.y0 + $signed({{PAD_W{1'b0}}, dy});
  assign on_screen = cur.in_bounds && !px[ssb_pkg::COORD_W-1] && (px < W_LIM)
                   && !py[ssb_pkg::COORD_W-1] && (py < H_LIM);
  assign addr_full = ssb_pkg::ADDR_FULL_W'(py[ssb_pkg::COORD_W-2:0]) * W_MUL
                   + ssb_pkg::ADDR_FULL_W'(px[ssb_pkg::COORD_W-2:0]);

  // current block and offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      dx        <= '0;
      dy        <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      dx        <= '0;
      dy        <= '0;
    end else if (step) begin
      if (!last_x) begin
        dx <= dx + ssb_pkg::OFS_W'(1);
      end else if (!last_y) begin
        dx <= '0;
        dy <= dy + ssb_pkg::OFS_W'(1);
      end else begin
        cur_valid <= 1'b0;
        dx        <= '0;
        dy        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wr.valid <= 1'b0;
    end else if (advance) begin
      wr.valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      wr.fb_address   <= on_screen ? addr_full[ssb_pkg::ADDR_W-1:0] : '0;
      wr.fb_color     <= cur.color;
      wr.write_enable <= on_screen;
      wr.last_write   <= last_x && last_y;
    end
  end

  a_dx_in_block: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, dx} < cur.scale))
    else $error("column offset beyond block");

  a_dy_in_block: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, dy} < cur.scale))
    else $error("row offset beyond block");

  a_addr_on_screen: assert property (@(posedge clk) disable iff (rst)
    (wr.valid && wr.write_enable && AREA_FITS) |-> ({1'b0, wr.fb_address} < AREA_LIM))
    else $error("enabled write outside framebuffer");

  a_clipped_zero: assert property (@(posedge clk) disable iff (rst)
    (wr.valid && !wr.write_enable) |-> (wr.fb_address == '0))
    else $error("clipped write carries an address");

endmodule

### sv/scaled_sprite_pixel_blitter.sv
// Top level: scaled sprite pixel blitter with APB scale register.
// Each accepted pixel beat becomes scale x scale framebuffer write beats, row by row, at
// one write beat per cycle while wr.ready is not holding the output; that walk sets the
// sustained rate. Scale 0 acts as 1 and values above MAX_SCALE saturate. Points off
// screen, and every point of a pixel whose row or column is outside the sprite, give a
// beat with write_enable low and address 0; the last beat of each block has last_write
// high. A two-entry job queue lets the input keep taking pixels while the back end is
// busy; a pixel's first write passes through the queue slot, block and output registers.
// Write the scale register (byte address 0) only while no block is in flight.
module scaled_sprite_pixel_blitter #(
  parameter int SCREEN_W        = ssb_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H        = ssb_pkg::SCREEN_H_DEF,
  parameter int MAX_SCALE       = ssb_pkg::MAX_SCALE_DEF,
  parameter int SPRITE_MAX_SIDE = ssb_pkg::SPRITE_MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ssb_pix_if.sink                       pix,
  ssb_wr_if.source                      wr,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssb_pkg::APB_AW-1:0]    paddr,
  input  logic [ssb_pkg::APB_DW-1:0]    pwdata,
  output logic [ssb_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [ssb_pkg::SCALE_W-1:0] scale_factor;
  logic                        cfg_wr;
  logic                        q_ready;
  logic                        q_push;
  ssb_pkg::ssb_job_t           push_job;
  logic                        q_valid;
  logic                        q_pop;
  ssb_pkg::ssb_job_t           pop_job;

  // APB: zero wait states, register index in paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ssb_pkg::REG_SCALE_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= ssb_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      scale_factor <= pwdata[ssb_pkg::SCALE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ssb_pkg::REG_SCALE_FACTOR)
                ? ssb_pkg::APB_DW'(scale_factor) : '0;

  // front end: origin, clip-by-sprite flag and effective scale
  ssb_front #(
    .MAX_SCALE       (MAX_SCALE),
    .SPRITE_MAX_SIDE (SPRITE_MAX_SIDE)
  ) u_front (
    .pix          (pix),
    .scale_factor (scale_factor),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  ssb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  // back end: block walk, screen clip, address and output register
  ssb_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .wr      (wr)
  );

endmodule
